@@ src/asdc_pkg.sv @@
package asdc_pkg;

  localparam logic [31:0] POLL_MS = 32'd20;
  localparam logic [23:0] FILT_RESET = 24'h100000;
  localparam int DIV_W = 27;
  localparam int DIV_CNT_W = 5;

  localparam logic [2:0] REG_PEAK = 3'd0;
  localparam logic [2:0] REG_VALLEY = 3'd1;
  localparam logic [2:0] REG_MIN_INT = 3'd2;
  localparam logic [2:0] REG_BASE = 3'd3;
  localparam logic [2:0] REG_MULT = 3'd4;
  localparam logic [2:0] REG_FEED = 3'd5;

  typedef enum logic [1:0] {
    DIV_FILT,
    DIV_STEP,
    DIV_MANUAL
  } div_mode_t;

  typedef struct packed {
    logic      load_in;
    logic      clear_flags;
    logic      sq_clear;
    logic      sq_acc;
    logic      sqrt_start;
    logic      div_start;
    div_mode_t div_mode;
    logic      mark_sample;
    logic      smooth_upd;
    logic      hyst_upd;
    logic      step_mark;
    logic      commit;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic manual;
    logic manual_ok;
    logic poll_ok;
    logic sq_last;
    logic sqrt_busy;
    logic div_busy;
    logic step_go;
    logic out_busy;
  } sts_t;

  function automatic logic [7:0] mult_lookup(input logic [2:0] idx);
    logic [7:0] m;
    unique case (idx)
      3'd0: m = 8'd1;
      3'd1: m = 8'd2;
      3'd2: m = 8'd5;
      3'd3: m = 8'd10;
      3'd4: m = 8'd25;
      3'd5: m = 8'd100;
      3'd6: m = 8'd250;
      default: m = 8'd1;
    endcase
    return m;
  endfunction

endpackage

@@ src/asdc_ctrl.sv @@
module asdc_ctrl
  import asdc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SQ,
    S_SQRT_GO,
    S_SQRT,
    S_FILT_GO,
    S_FDIV,
    S_SMOOTH,
    S_HYST,
    S_SDIV,
    S_COMMIT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.div_mode = DIV_FILT;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.clear_flags = 1'b1;
        cmd.sq_clear = 1'b1;
        if (sts.manual) begin
          if (sts.manual_ok) begin
            cmd.div_start = 1'b1;
            cmd.div_mode = DIV_MANUAL;
            state_nxt = S_SDIV;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (sts.poll_ok) begin
          cmd.mark_sample = 1'b1;
          state_nxt = S_SQ;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SQ: begin
        cmd.sq_acc = 1'b1;
        if (sts.sq_last) state_nxt = S_SQRT_GO;
      end
      S_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (!sts.sqrt_busy) state_nxt = S_FILT_GO;
      end
      S_FILT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_mode = DIV_FILT;
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        if (!sts.div_busy) state_nxt = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd.smooth_upd = 1'b1;
        state_nxt = S_HYST;
      end
      S_HYST: begin
        cmd.hyst_upd = 1'b1;
        if (sts.step_go) begin
          cmd.step_mark = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_mode = DIV_STEP;
          state_nxt = S_SDIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SDIV: begin
        if (!sts.div_busy) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/asdc_dp.sv @@
module asdc_dp
  import asdc_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_req_type,
  input  logic signed [AW-1:0] in_accel_x,
  input  logic signed [AW-1:0] in_accel_y,
  input  logic signed [AW-1:0] in_accel_z,
  input  logic [31:0]          in_time_ms,
  input  logic signed [15:0]   in_step_count,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_sample_accepted,
  output logic                 out_step_detected,
  output logic [24:0]          out_feed_amount,
  output logic [31:0]          out_total_steps,
  output logic [15:0]          out_steps_until_batch,
  output logic [15:0]          out_filtered_magnitude,
  output logic                 out_is_armed
);

  localparam int SW = 2 * AW + 2;
  localparam int K = AW + 1;
  localparam int CW = $clog2(K + 1);
  // Division by five as a multiply by ceil(2^29 / 5) and a shift by 29.
  localparam logic [DIV_W-1:0] RECIP5 = DIV_W'(107374183);

  logic [15:0] peak_r, valley_r, min_int_r, base_r, need_r;
  logic [2:0]  midx_r;
  logic [7:0]  feedpb_r;
  logic        clamp1_r, clamp2_r;
  logic [23:0] need_prod;
  logic [15:0] need_nxt;

  logic          rtype_r;
  logic [AW-1:0] ax_r, ay_r, az_r;
  logic [31:0]   now_r;
  logic [15:0]   sc_r;

  logic [31:0] total_r, last_step_r, last_samp_r;
  logic [15:0] rem_r;
  logic        armed_r;
  logic [23:0] smooth_r;

  logic [1:0]      sq_cnt_r;
  logic [AW-1:0]   sq_sel;
  logic [2*AW-1:0] prod_r;
  logic [SW-1:0]   sum_r;

  logic [SW-1:0]  src_r;
  logic [K+1:0]   srem_r;
  logic [K-1:0]   root_r;
  logic [CW-1:0]  scnt_r;
  logic           sbusy_r;
  logic [K+3:0]   srem_t, strial;
  logic [39:0]    root_w;
  logic [15:0]    mag16;

  logic [DIV_W-1:0]     dvd_r;
  logic [15:0]          dr_r, dd_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic                 dbusy_r;
  logic [16:0]          dr_t;
  logic                 dge;
  logic [14:0]          n_r;
  logic [2*DIV_W-1:0]   filt_prod_r;

  logic        accepted_r, detected_r;
  logic [24:0] feed_r;
  logic        out_valid_r;
  logic [15:0] steps_left;

  function automatic logic [AW-1:0] abs_f(input logic [AW-1:0] v);
    return v[AW-1] ? (~v + 1'b1) : v;
  endfunction

  assign need_prod = base_r * mult_lookup(midx_r);
  assign need_nxt = (need_prod == 24'd0) ? 16'd1 :
                    (|need_prod[23:16]) ? 16'hFFFF : need_prod[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= 16'd4915;
      valley_r <= 16'd3891;
      min_int_r <= 16'd250;
      base_r <= 16'd100;
      midx_r <= 3'd0;
      feedpb_r <= 8'd1;
      clamp1_r <= 1'b0;
      clamp2_r <= 1'b0;
      need_r <= 16'd100;
    end else begin
      need_r <= need_nxt;
      clamp1_r <= cfg_we && (cfg_index == REG_MULT);
      clamp2_r <= clamp1_r;
      if (cfg_we) begin
        case (cfg_index)
          REG_PEAK:    peak_r <= cfg_data;
          REG_VALLEY:  valley_r <= cfg_data;
          REG_MIN_INT: min_int_r <= cfg_data;
          REG_BASE:    base_r <= cfg_data;
          REG_MULT:    midx_r <= cfg_data[2:0];
          REG_FEED:    feedpb_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rtype_r <= in_req_type;
      ax_r <= abs_f(in_accel_x);
      ay_r <= abs_f(in_accel_y);
      az_r <= abs_f(in_accel_z);
      now_r <= in_time_ms;
      sc_r <= in_step_count;
    end
  end

  always_comb begin
    case (sq_cnt_r)
      2'd0: sq_sel = ax_r;
      2'd1: sq_sel = ay_r;
      2'd2: sq_sel = az_r;
      default: sq_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_clear) begin
      sq_cnt_r <= 2'd0;
      prod_r <= '0;
      sum_r <= '0;
    end else if (cmd.sq_acc) begin
      sq_cnt_r <= sq_cnt_r + 2'd1;
      prod_r <= sq_sel * sq_sel;
      sum_r <= sum_r + SW'(prod_r);
    end
  end

  assign srem_t = {srem_r, src_r[SW-1 -: 2]};
  assign strial = {2'b00, root_r, 2'b01};
  assign root_w = {{(40 - K){1'b0}}, root_r};
  assign mag16 = (|root_w[39:16]) ? 16'hFFFF : root_w[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sbusy_r <= 1'b1;
      src_r <= sum_r;
      srem_r <= '0;
      root_r <= '0;
      scnt_r <= '0;
    end else if (sbusy_r) begin
      src_r <= {src_r[SW-3:0], 2'b00};
      if (srem_t >= strial) begin
        srem_r <= (K+2)'(srem_t - strial);
        root_r <= {root_r[K-2:0], 1'b1};
      end else begin
        srem_r <= srem_t[K+1:0];
        root_r <= {root_r[K-2:0], 1'b0};
      end
      scnt_r <= scnt_r + 1'b1;
      if (scnt_r == CW'(K - 1)) sbusy_r <= 1'b0;
    end
  end

  assign dr_t = {dr_r, dvd_r[DIV_W-1]};
  assign dge = dr_t >= {1'b0, dd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy_r <= (cmd.div_mode != DIV_FILT);
      dr_r <= '0;
      dcnt_r <= '0;
      case (cmd.div_mode)
        DIV_FILT: begin
          dvd_r <= DIV_W'({smooth_r, 2'b00}) + DIV_W'({mag16, 8'h00}) + DIV_W'(2);
        end
        DIV_STEP: begin
          dvd_r <= DIV_W'(rem_r) + DIV_W'(1);
          dd_r <= need_r;
          n_r <= 15'd1;
        end
        default: begin
          dvd_r <= DIV_W'(rem_r) + DIV_W'(sc_r[14:0]);
          dd_r <= need_r;
          n_r <= sc_r[14:0];
        end
      endcase
    end else if (dbusy_r) begin
      dr_r <= dge ? 16'(dr_t - {1'b0, dd_r}) : dr_t[15:0];
      dvd_r <= {dvd_r[DIV_W-2:0], dge};
      dcnt_r <= dcnt_r + 1'b1;
      if (dcnt_r == DIV_CNT_W'(DIV_W - 1)) dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    filt_prod_r <= dvd_r * RECIP5;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      rem_r <= '0;
      armed_r <= 1'b0;
      smooth_r <= FILT_RESET;
      last_step_r <= '0;
      last_samp_r <= '0;
      accepted_r <= 1'b0;
      detected_r <= 1'b0;
      feed_r <= '0;
    end else begin
      if (clamp2_r && (rem_r >= need_r)) rem_r <= need_r - 16'd1;
      if (cmd.clear_flags) begin
        accepted_r <= cmd.mark_sample;
        detected_r <= 1'b0;
        feed_r <= '0;
      end
      if (cmd.mark_sample) begin
        last_samp_r <= now_r;
      end
      if (cmd.smooth_upd) smooth_r <= filt_prod_r[52:29];
      if (cmd.hyst_upd) begin
        if (!armed_r) begin
          if (smooth_r > {peak_r, 8'h00}) armed_r <= 1'b1;
        end else if (smooth_r <= {valley_r, 8'h00}) begin
          armed_r <= 1'b0;
        end
      end
      if (cmd.step_mark) begin
        detected_r <= 1'b1;
        last_step_r <= now_r;
      end
      if (cmd.commit) begin
        rem_r <= dr_r;
        total_r <= total_r + 32'(n_r);
        feed_r <= 25'(dvd_r[16:0] * feedpb_r);
      end
    end
  end

  assign steps_left = (rem_r >= need_r) ? 16'd0 : need_r - rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_accepted <= accepted_r;
      out_step_detected <= detected_r;
      out_feed_amount <= feed_r;
      out_total_steps <= total_r;
      out_steps_until_batch <= steps_left;
      out_filtered_magnitude <= smooth_r[23:8];
      out_is_armed <= armed_r;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.manual = rtype_r;
  assign sts.manual_ok = !sc_r[15] && (|sc_r);
  assign sts.poll_ok = (now_r - last_samp_r) >= POLL_MS;
  assign sts.sq_last = (sq_cnt_r == 2'd3);
  assign sts.sqrt_busy = sbusy_r;
  assign sts.div_busy = dbusy_r;
  assign sts.step_go = armed_r && (smooth_r <= {valley_r, 8'h00}) &&
                       ((now_r - last_step_r) >= {16'h0000, min_int_r});
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

@@ src/accel_step_detector_counter.sv @@
// Step detector and step counter for accelerometer samples.
// Requests enter on the in_ channel (in_valid, in_stall): a request is either
// an accelerometer sample with a millisecond timestamp or a number of steps to
// add. Each request yields exactly one result on the out_ channel (out_valid,
// out_stall) carrying the step total, batch progress, feed grant and filter.
// One request is processed at a time. A manual step request passes through
// the restoring divider that splits the steps into batches. A sample that
// counts a step passes through the squares, the bit-serial square root, a
// reciprocal multiply for the filter and one divider pass for the batch
// count. A sample without a step skips the divider pass; an ignored sample
// skips all of these. in_stall is low only while the block is idle.
// A finished result waits in the output register while the next request is
// already accepted; when the receiver stalls, the block holds a completed
// result until the output register frees up. Configuration registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while no request is in flight, as the block does not enforce this.
// Synchronous reset restores the configuration registers to their defaults,
// clears the step total and batch remainder, and sets the filter to 1.0 g.
module accel_step_detector_counter
  import asdc_pkg::*;
#(
  parameter int ACCEL_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic signed [ACCEL_WIDTH-1:0] in_accel_x,
  input  logic signed [ACCEL_WIDTH-1:0] in_accel_y,
  input  logic signed [ACCEL_WIDTH-1:0] in_accel_z,
  input  logic [31:0]                   in_time_ms,
  input  logic signed [15:0]            in_step_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_sample_accepted,
  output logic                          out_step_detected,
  output logic [24:0]                   out_feed_amount,
  output logic [31:0]                   out_total_steps,
  output logic [15:0]                   out_steps_until_batch,
  output logic [15:0]                   out_filtered_magnitude,
  output logic                          out_is_armed
);

  cmd_t cmd;
  sts_t sts;

  asdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  asdc_dp #(
    .AW (ACCEL_WIDTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_req_type            (in_req_type),
    .in_accel_x             (in_accel_x),
    .in_accel_y             (in_accel_y),
    .in_accel_z             (in_accel_z),
    .in_time_ms             (in_time_ms),
    .in_step_count          (in_step_count),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_sample_accepted    (out_sample_accepted),
    .out_step_detected      (out_step_detected),
    .out_feed_amount        (out_feed_amount),
    .out_total_steps        (out_total_steps),
    .out_steps_until_batch  (out_steps_until_batch),
    .out_filtered_magnitude (out_filtered_magnitude),
    .out_is_armed           (out_is_armed)
  );

endmodule

@@ src/asdc_checker.sv @@
module asdc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_sample_accepted,
  input logic out_step_detected,
  input logic out_is_armed,
  input logic [31:0] out_total_steps
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without going busy");

  a_step_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_detected |-> out_sample_accepted)
    else $error("step reported without an accepted sample");

  a_step_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_detected |-> !out_is_armed)
    else $error("step reported while still armed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_total_steps))
    else $error("stalled result changed");

endmodule

bind accel_step_detector_counter asdc_checker u_asdc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_sample_accepted (out_sample_accepted),
  .out_step_detected   (out_step_detected),
  .out_is_armed        (out_is_armed),
  .out_total_steps     (out_total_steps)
);
